@@ hw/rtl/lvc_pkg.sv @@
// lvc_pkg: shared types and constants for the LZW varint compressor.
// No dependencies.
package lvc_pkg;

   // Default sizes
   localparam int DICT_SIZE_DEF  = 4096;
   localparam int HASH_SLOTS_DEF = 8192;

   // Widest code the varint path handles (DICT_SIZE up to 16384)
   localparam int VARINT_CODE_W = 14;

   // Dictionary epoch tag; tag zero marks a cleared slot
   localparam int EPOCH_W = 8;

   // Multiplicative hash constant
   localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

   localparam logic [7:0] VARINT_MASK = 8'h7F;
   localparam logic [7:0] VARINT_MORE = 8'h80;

   // Input item as it sits in the request queue
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // Result item as it sits in the response queue
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

endpackage

@@ hw/rtl/lvc_fifo.sv @@
// lvc_fifo: small register FIFO, used for the request and response queues.
// Depends on nothing; DEPTH must be a power of two.
module lvc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   // Status from pointer distance
   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                    (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= wr_data;
      end
   end

endmodule

@@ hw/rtl/lvc_engine.sv @@
// lvc_engine: back end of the compressor: hash, dictionary probe and insert,
// varint emission. Depends on lvc_pkg.
module lvc_engine #(
   parameter int DICT_SIZE  = lvc_pkg::DICT_SIZE_DEF,
   parameter int HASH_SLOTS = lvc_pkg::HASH_SLOTS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  lvc_pkg::req_type in_item,
   output logic            in_pop,
   input  logic            out_full,
   output logic            out_push,
   output lvc_pkg::rsp_type out_item
);
   import lvc_pkg::*;

   localparam int CW = $clog2(DICT_SIZE);
   localparam int HB = $clog2(HASH_SLOTS);
   localparam int MW = EPOCH_W + CW + 8 + CW;
   localparam logic [CW:0]      FIRST_FREE = (CW+1)'(256);
   localparam logic [CW:0]      DICT_LIMIT = (CW+1)'(DICT_SIZE);
   localparam logic [HB-1:0]    SLOT_LAST  = HB'(HASH_SLOTS - 1);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_ADDR, ST_READ, ST_CMP, ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [HB-1:0]    clr_ff, clr_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [CW-1:0]    prefix_ff, prefix_in;
   logic             pvalid_ff, pvalid_in;
   logic [CW:0]      next_ff, next_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [31:0]      prod_ff, prod_in;
   logic [HB-1:0]    slot_ff, slot_in;
   logic [HB-1:0]    probe_ff, probe_in;
   logic [7:0]       stage_ff [4];
   logic [7:0]       stage_in [4];
   logic [2:0]       n_ff, n_in;
   logic [1:0]       idx_ff, idx_in;
   logic             end_ff, end_in;
   logic             wrap_ff, wrap_in;

   logic [MW-1:0]    mem [HASH_SLOTS];
   logic [MW-1:0]    rd_ff;
   logic             mem_we;
   logic [HB-1:0]    mem_wa;
   logic [MW-1:0]    mem_wd;

   logic [EPOCH_W-1:0] rd_epoch;
   logic [CW-1:0]    rd_prefix;
   logic [7:0]       rd_byte;
   logic [CW-1:0]    rd_code;

   logic             dec;
   logic             dec_emit;
   logic [CW-1:0]    dec_code;
   logic [CW-1:0]    dec_prefix;
   logic             dec_last;
   logic [31:0]      hash_key;

   // Low and high varint bytes of a code
   function automatic logic [7:0] vb_lo(input logic [CW-1:0] code);
      logic [VARINT_CODE_W-1:0] c;
      c = VARINT_CODE_W'(code);
      return (c[7:0] & VARINT_MASK) | ((|c[VARINT_CODE_W-1:7]) ? VARINT_MORE : 8'h00);
   endfunction

   function automatic logic [7:0] vb_hi(input logic [CW-1:0] code);
      logic [VARINT_CODE_W-1:0] c;
      c = VARINT_CODE_W'(code);
      return 8'(c[VARINT_CODE_W-1:7]);
   endfunction

   function automatic logic [2:0] vb_len(input logic [CW-1:0] code);
      logic [VARINT_CODE_W-1:0] c;
      c = VARINT_CODE_W'(code);
      return (|c[VARINT_CODE_W-1:7]) ? 3'd2 : 3'd1;
   endfunction

   assign {rd_epoch, rd_prefix, rd_byte, rd_code} = rd_ff;
   assign hash_key = {8'h00, 16'(prefix_ff), byte_ff};

   // Result on the response queue
   assign out_item.out_byte   = stage_ff[idx_ff];
   assign out_item.run_last   = (3'(idx_ff) == n_ff - 3'd1);
   assign out_item.stream_end = end_ff && (3'(idx_ff) == n_ff - 3'd1);

   // Next-state logic
   always_comb begin
      logic [2:0] a_n;
      state_in = state_ff;
      clr_in   = clr_ff;
      epoch_in = epoch_ff;
      prefix_in = prefix_ff;
      pvalid_in = pvalid_ff;
      next_in  = next_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      prod_in  = prod_ff;
      slot_in  = slot_ff;
      probe_in = probe_ff;
      stage_in = stage_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      end_in   = end_ff;
      wrap_in  = wrap_ff;
      in_pop   = 1'b0;
      out_push = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = slot_ff;
      mem_wd   = {epoch_ff, prefix_ff, byte_ff, next_ff[CW-1:0]};
      dec      = 1'b0;
      dec_emit = 1'b0;
      dec_code = prefix_ff;
      dec_prefix = prefix_ff;
      dec_last = last_ff;
      a_n      = 3'd0;

      case (state_ff)
         // Sweep all slots to the cleared tag
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SLOT_LAST) begin
               epoch_in = EPOCH_W'(1);
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (in_valid) begin
               in_pop  = 1'b1;
               byte_in = in_item.in_byte;
               last_in = in_item.in_last;
               if (!pvalid_ff) begin
                  dec        = 1'b1;
                  dec_prefix = CW'(in_item.in_byte);
                  dec_last   = in_item.in_last;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            prod_in  = hash_key * HASH_MULT;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            slot_in  = prod_ff[HB-1:0];
            probe_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         // Check one slot of the probe sequence
         ST_CMP: begin
            if (rd_epoch != epoch_ff || (rd_prefix != prefix_ff || rd_byte != byte_ff)
                && probe_ff == SLOT_LAST) begin
               dec        = 1'b1;
               dec_emit   = 1'b1;
               dec_prefix = CW'(byte_ff);
               if (next_ff < DICT_LIMIT) begin
                  mem_we  = (rd_epoch != epoch_ff);
                  next_in = next_ff + 1'b1;
               end
            end else if (rd_prefix == prefix_ff && rd_byte == byte_ff) begin
               dec        = 1'b1;
               dec_prefix = rd_code;
            end else begin
               slot_in  = slot_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (3'(idx_ff) == n_ff - 3'd1) begin
                  if (wrap_ff) begin
                     wrap_in  = 1'b0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      // Common end of an item: stage result bytes, update prefix
      if (dec) begin
         if (dec_emit) begin
            a_n = vb_len(dec_code);
            stage_in[0] = vb_lo(dec_code);
            stage_in[1] = vb_hi(dec_code);
         end
         if (dec_last) begin
            if (a_n == 3'd2) begin
               stage_in[2] = vb_lo(dec_prefix);
               stage_in[3] = vb_hi(dec_prefix);
            end else if (a_n == 3'd1) begin
               stage_in[1] = vb_lo(dec_prefix);
               stage_in[2] = vb_hi(dec_prefix);
            end else begin
               stage_in[0] = vb_lo(dec_prefix);
               stage_in[1] = vb_hi(dec_prefix);
            end
            n_in      = a_n + vb_len(dec_prefix);
            prefix_in = '0;
            pvalid_in = 1'b0;
            next_in   = FIRST_FREE;
            epoch_in  = epoch_ff + 1'b1;
            wrap_in   = (epoch_ff == EPOCH_MAX);
         end else begin
            n_in      = a_n;
            prefix_in = dec_prefix;
            pvalid_in = 1'b1;
         end
         end_in   = dec_last;
         idx_in   = '0;
         state_in = (dec_last || dec_emit) ? ST_EMIT : ST_IDLE;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         epoch_ff  <= '0;
         prefix_ff <= '0;
         pvalid_ff <= 1'b0;
         next_ff   <= FIRST_FREE;
         n_ff      <= '0;
         idx_ff    <= '0;
         end_ff    <= 1'b0;
         wrap_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         epoch_ff  <= epoch_in;
         prefix_ff <= prefix_in;
         pvalid_ff <= pvalid_in;
         next_ff   <= next_in;
         n_ff      <= n_in;
         idx_ff    <= idx_in;
         end_ff    <= end_in;
         wrap_ff   <= wrap_in;
      end
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      slot_ff  <= slot_in;
      probe_ff <= probe_in;
      stage_ff <= stage_in;
   end

   // Dictionary memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[slot_ff];
   end

endmodule

@@ hw/rtl/lzw_varint_compressor_top.sv @@
// LZW compressor with 7-bit varint code output. Bytes enter through a
// two-entry request queue; the engine takes one at a time, steps a byte that
// extends a prefix through idle, hash, address, read and compare (a stream's
// first byte through idle only), repeating read and compare per extra probe,
// then writes one result byte per cycle, while there is room, into the
// four-entry response queue. The hashed dictionary is a single-port-write,
// registered-read memory of HASH_SLOTS entries, cleared after reset and each
// 255th stream end while no byte is taken. HASH_SLOTS must be a power of two.
//
// Top level; depends on lvc_pkg, lvc_fifo and lvc_engine.
module lzw_varint_compressor_top #(
   parameter int DICT_SIZE  = lvc_pkg::DICT_SIZE_DEF,
   parameter int HASH_SLOTS = lvc_pkg::HASH_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);
   import lvc_pkg::*;

   req_type req_wr, req_rd;
   rsp_type rsp_wr, rsp_rd;
   logic    req_empty, req_pop;
   logic    rsp_full, rsp_push;

   assign req_wr.in_byte = req_in_byte;
   assign req_wr.in_last = req_in_last;

   // Front: request queue
   lvc_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_req_q (
      .clock(clock), .reset(reset),
      .push(req_push), .wr_data(req_wr), .full(req_full),
      .pop(req_pop), .rd_data(req_rd), .empty(req_empty)
   );

   // Back: dictionary engine
   lvc_engine #(.DICT_SIZE(DICT_SIZE), .HASH_SLOTS(HASH_SLOTS)) u_engine (
      .clock(clock), .reset(reset),
      .in_valid(!req_empty), .in_item(req_rd), .in_pop(req_pop),
      .out_full(rsp_full), .out_push(rsp_push), .out_item(rsp_wr)
   );

   // Response queue
   lvc_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(4)) u_rsp_q (
      .clock(clock), .reset(reset),
      .push(rsp_push), .wr_data(rsp_wr), .full(rsp_full),
      .pop(rsp_pop), .rd_data(rsp_rd), .empty(rsp_empty)
   );

   assign rsp_out_byte   = rsp_rd.out_byte;
   assign rsp_run_last   = rsp_rd.run_last;
   assign rsp_stream_end = rsp_rd.stream_end;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for lzw_varint_compressor_top, an LZW encoder with
// varint output. It predicts every compressed byte and checks each response transfer.
// Depends on lvc_pkg and the compressor RTL.
module tb_top;
   import lvc_pkg::*;

   // small dictionary so that one stream can fill it
   localparam int DICT_SIZE   = 512;
   localparam int FIRST_CODE  = 256;
   localparam int STALL_LIMIT = 40000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = '0;
   logic       req_in_last = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_stream_end;

   // encoder shadow state
   bit [11:0]   cur_prefix;
   bit          have_prefix;
   int unsigned free_code;
   int unsigned string_codes[bit [19:0]];

   rsp_type     pending_bytes[$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          error_count;
   int          bytes_in;
   int          bytes_out;
   int          streams_done;
   int          quiet_cycles;

   lzw_varint_compressor_top #(.DICT_SIZE(DICT_SIZE)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

   always #5 clock = ~clock;

   // append one code as a 1- or 2-byte varint
   function automatic void append_varint(input bit [11:0] code, ref rsp_type grp[$]);
      rsp_type r;
      bit [11:0] v;
      v = code;
      do begin
         r = '0;
         r.out_byte = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 0) r.out_byte = r.out_byte | VARINT_MORE;
         grp = {grp, r};
      end while (v != 0);
   endfunction

   // LZW step for one input byte; queues the bytes it produces
   function automatic void compress_byte(input bit [7:0] b, input bit last);
      rsp_type grp[$];
      bit [19:0] key;
      key = {cur_prefix, b};
      if (!have_prefix) begin
         cur_prefix  = {4'd0, b};
         have_prefix = 1'b1;
      end else if (string_codes.exists(key)) begin
         cur_prefix = string_codes[key][11:0];
      end else begin
         append_varint(cur_prefix, grp);
         if (free_code < DICT_SIZE) begin
            string_codes[key] = free_code;
            free_code++;
         end
         cur_prefix = {4'd0, b};
      end
      if (last) begin
         append_varint(cur_prefix, grp);
         grp[grp.size()-1].stream_end = 1'b1;
         cur_prefix  = '0;
         have_prefix = 1'b0;
         free_code   = FIRST_CODE;
         string_codes.delete();
      end
      if (grp.size() > 0) grp[grp.size()-1].run_last = 1'b1;
      pending_bytes = {pending_bytes, grp};
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // one input transfer, with random idle cycles ahead of it
   task automatic send_byte(input bit [7:0] b, input bit last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push    <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_full);
      compress_byte(b, last);
      bytes_in++;
      if (last) streams_done++;
   endtask

   // hold off input until every expected byte has come back
   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      wait (pending_bytes.size() == 0);
      repeat (30) @(negedge clock);
   endtask

   // receiver stalls at random
   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // response checker and stall watchdog
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
         if (rsp_pop && !rsp_empty) begin
            bytes_out++;
            if (pending_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h", rsp_out_byte));
            end else begin
               exp_r = pending_bytes.pop_front();
               if (rsp_out_byte !== exp_r.out_byte)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_out_byte, exp_r.out_byte));
               if (rsp_run_last !== exp_r.run_last)
                  report_mismatch($sformatf("run_last %b, expected %b",
                                            rsp_run_last, exp_r.run_last));
               if (rsp_stream_end !== exp_r.stream_end)
                  report_mismatch($sformatf("stream_end %b, expected %b",
                                            rsp_stream_end, exp_r.stream_end));
            end
         end
      end
   end

   // one-byte streams at both byte extremes, repeats that build long codes
   task automatic test_directed();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      for (int i = 0; i < 12; i++) send_byte((i % 2) ? 8'hFF : 8'h00, i == 11);
      for (int i = 0; i < 10; i++) send_byte(8'h41, i == 9);
   endtask

   // random streams, mostly over a small alphabet so strings repeat
   task automatic test_random_streams(input int n_items);
      int len;
      bit [7:0] b;
      while (n_items > 0) begin
         len = int'($urandom_range(30, 1));
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) < 7) b = 8'(8'h60 + $urandom_range(3));
            else b = 8'($urandom_range(255));
            send_byte(b, i == len - 1);
         end
         n_items -= len;
      end
   endtask

   // one long random stream that fills the dictionary
   task automatic test_dict_full();
      for (int i = 0; i < 270; i++) send_byte(8'($urandom_range(255)), i == 269);
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      error_count   = 0;
      bytes_in      = 0;
      bytes_out     = 0;
      streams_done  = 0;
      quiet_cycles  = 0;
      have_prefix   = 1'b0;
      cur_prefix    = '0;
      free_code     = FIRST_CODE;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      drain();
      send_idle_pct = 8;
      recv_idle_pct = 88;
      test_random_streams(15);
      send_idle_pct = 88;
      recv_idle_pct = 8;
      test_random_streams(15);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_dict_full();
      drain();

      $display("Covered %0d input bytes in %0d streams, %0d compressed bytes checked,",
               bytes_in, streams_done, bytes_out);
      $display("including one-byte streams and a stream that fills the dictionary.");
      if (error_count == 0 && pending_bytes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d bytes missing", error_count, pending_bytes.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/lvc_pkg.sv
hw/rtl/lvc_fifo.sv
hw/rtl/lvc_engine.sv
hw/rtl/lzw_varint_compressor_top.sv
sim/tb_top.sv
